// ===== design/gmv_pkg.sv =====
// Shared constants and types for the group mean vector unit.
`timescale 1ns / 1ps

package gmv_pkg;

    localparam int DEF_MAX_CHANNELS = 512;
    localparam int DEF_MAX_GROUP    = 256;
    localparam int DEF_DATA_WIDTH   = 16;

    localparam int GROUP_SIZE_W    = 9;
    localparam int CHANNEL_COUNT_W = 10;
    localparam int INV_W           = 17;
    localparam int CFG_DATA_W      = 17;
    localparam int CFG_INDEX_W     = 2;

    localparam int ACC_W  = 24;
    localparam int FRAC_W = 16;

    localparam logic [GROUP_SIZE_W-1:0]    GROUP_SIZE_RST    = GROUP_SIZE_W'(1);
    localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RST = CHANNEL_COUNT_W'(1);
    localparam logic [INV_W-1:0]           INV_GROUP_SIZE_RST = INV_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GROUP_SIZE     = 2'd0,
        CFG_CHANNEL_COUNT  = 2'd1,
        CFG_INV_GROUP_SIZE = 2'd2
    } cfg_index_t;

endpackage

// ===== design/group_mean_vector_unit.sv =====
// Top level of the group mean vector unit: per-channel sum memory, scaling and output register.
`timescale 1ns / 1ps

// The unit takes one sample transaction per cycle while neither the clearing pass nor a
// stalled output holds it, and averages consecutive groups of rows per channel, giving one
// mean transaction for every sample of the last row of a group. The per-channel sums live in
// a single-port-write, single-port-read memory that is read when a sample is accepted and
// written back as it leaves the accumulate stage, with forwarding of the most recent write;
// this read-modify-write loop sets that rate of one sample per cycle. A mean passes from the
// accumulate stage through the scale stage to the output register. After reset the unit
// clears the whole sum memory, stalling samples, and takes configuration writes throughout.
module group_mean_vector_unit
    import gmv_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_GROUP    = DEF_MAX_GROUP,
    parameter int DATA_WIDTH   = DEF_DATA_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [DATA_WIDTH-1:0] sample_value,

    output logic                         mean_valid,
    input  logic                         mean_stall,
    output logic signed [DATA_WIDTH-1:0] mean_value,
    output logic                         vector_end
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ROW_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CC_W  = ($clog2(MAX_CHANNELS + 1) > CHANNEL_COUNT_W) ?
                           $clog2(MAX_CHANNELS + 1) : CHANNEL_COUNT_W;
    localparam int RC_W  = ($clog2(MAX_GROUP + 1) > GROUP_SIZE_W) ?
                           $clog2(MAX_GROUP + 1) : GROUP_SIZE_W;
    localparam int TOT_W  = ((ACC_W > DATA_WIDTH) ? ACC_W : DATA_WIDTH) + 1;
    localparam int PROD_W = TOT_W + INV_W + 1;
    localparam int Q_W    = PROD_W - FRAC_W;

    localparam logic [CC_W-1:0] CHANS_MAX = CC_W'(MAX_CHANNELS);
    localparam logic [CC_W-1:0] CH_LAST   = CC_W'(MAX_CHANNELS - 1);
    localparam logic [RC_W-1:0] ROWS_MAX  = RC_W'(MAX_GROUP);

    localparam logic signed [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_NEG_MAX = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] MEAN_POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MEAN_NEG_MAX = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Configuration registers.
    logic [GROUP_SIZE_W-1:0]    group_size_reg;
    logic [CHANNEL_COUNT_W-1:0] channel_count_reg;
    logic [INV_W-1:0]           inv_group_size_reg;

    // Stream position.
    logic [CH_W-1:0]  ch_pos_reg;
    logic [CH_W-1:0]  ch_pos_next;
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;

    // Clearing pass.
    logic            clr_active_reg;
    logic [CH_W-1:0] clr_addr_reg;

    // Sum memory and the last write, kept for forwarding.
    logic signed [ACC_W-1:0] sum_mem [MAX_CHANNELS];
    logic signed [ACC_W-1:0] rd_data_reg;
    logic [CH_W-1:0]         fwd_addr_reg;
    logic signed [ACC_W-1:0] fwd_data_reg;
    logic                    wr_en;
    logic [CH_W-1:0]         wr_addr;
    logic signed [ACC_W-1:0] wr_data;

    // Accumulate stage.
    logic                         s1_valid_reg;
    logic [CH_W-1:0]              s1_ch_reg;
    logic signed [DATA_WIDTH-1:0] s1_x_reg;
    logic                         s1_last_row_reg;
    logic                         s1_last_chan_reg;

    // Scale stage.
    logic                    s2_valid_reg;
    logic signed [TOT_W-1:0] s2_total_reg;
    logic                    s2_end_reg;

    // Output register.
    logic                         mean_valid_reg;
    logic signed [DATA_WIDTH-1:0] mean_value_reg;
    logic                         vector_end_reg;

    logic                    accept;
    logic                    out_ready;
    logic                    s2_ready;
    logic                    s2_move;
    logic                    s1_move;
    logic                    s1_ready;
    logic [CC_W-1:0]         chans_eff;
    logic [RC_W-1:0]         rows_eff;
    logic [CH_W-1:0]         ch_eff;
    logic                    last_chan;
    logic                    last_row;
    logic signed [ACC_W-1:0] sum_cur;
    logic signed [TOT_W-1:0] total;
    logic signed [ACC_W-1:0] sum_new;
    logic                    total_fits;
    logic signed [PROD_W-1:0] prod;
    logic signed [Q_W-1:0]    q;
    logic                     q_fits;
    logic signed [DATA_WIDTH-1:0] mean_next;

    // Handshake and stage movement.
    assign out_ready    = !mean_valid_reg || !mean_stall;
    assign s2_move      = s2_valid_reg && out_ready;
    assign s2_ready     = !s2_valid_reg || out_ready;
    assign s1_move      = s1_valid_reg && (!s1_last_row_reg || s2_ready);
    assign s1_ready     = !s1_valid_reg || s1_move;
    assign sample_stall = clr_active_reg || !s1_ready;
    assign accept       = sample_valid && !sample_stall;

    // Position decode for the incoming sample.
    always_comb
    begin
        chans_eff = CC_W'(channel_count_reg);
        if (chans_eff == '0)
        begin
            chans_eff = CC_W'(1);
        end
        else if (chans_eff > CHANS_MAX)
        begin
            chans_eff = CHANS_MAX;
        end

        rows_eff = RC_W'(group_size_reg);
        if (rows_eff == '0)
        begin
            rows_eff = RC_W'(1);
        end
        else if (rows_eff > ROWS_MAX)
        begin
            rows_eff = ROWS_MAX;
        end

        ch_eff = ch_pos_reg;
        if (CC_W'(ch_pos_reg) > CH_LAST)
        begin
            ch_eff = CH_LAST[CH_W-1:0];
        end

        last_chan = (CC_W'(ch_eff) >= chans_eff - CC_W'(1));
        last_row  = (RC_W'(row_pos_reg) >= rows_eff - RC_W'(1));

        if (last_chan)
        begin
            ch_pos_next  = '0;
            row_pos_next = last_row ? '0 : row_pos_reg + ROW_W'(1);
        end
        else
        begin
            ch_pos_next  = ch_eff + CH_W'(1);
            row_pos_next = row_pos_reg;
        end
    end

    // Accumulate: the group's last row clears the sum, other rows add with saturation.
    always_comb
    begin
        sum_cur    = (fwd_addr_reg == s1_ch_reg) ? fwd_data_reg : rd_data_reg;
        total      = TOT_W'(sum_cur) + TOT_W'(s1_x_reg);
        total_fits = (&total[TOT_W-1:ACC_W-1]) || !(|total[TOT_W-1:ACC_W-1]);
        if (s1_last_row_reg)
        begin
            sum_new = '0;
        end
        else if (total_fits)
        begin
            sum_new = total[ACC_W-1:0];
        end
        else
        begin
            sum_new = total[TOT_W-1] ? ACC_NEG_MAX : ACC_POS_MAX;
        end
    end

    assign wr_en   = clr_active_reg || s1_move;
    assign wr_addr = clr_active_reg ? clr_addr_reg : s1_ch_reg;
    assign wr_data = clr_active_reg ? '0 : sum_new;

    // Scale by the reciprocal, floor the Q16 product and saturate.
    always_comb
    begin
        prod      = PROD_W'(s2_total_reg) * PROD_W'($signed({1'b0, inv_group_size_reg}));
        q         = prod[PROD_W-1:FRAC_W];
        q_fits    = (&q[Q_W-1:DATA_WIDTH-1]) || !(|q[Q_W-1:DATA_WIDTH-1]);
        mean_next = q_fits ? q[DATA_WIDTH-1:0] : (q[Q_W-1] ? MEAN_NEG_MAX : MEAN_POS_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg     <= GROUP_SIZE_RST;
            channel_count_reg  <= CHANNEL_COUNT_RST;
            inv_group_size_reg <= INV_GROUP_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GROUP_SIZE:     group_size_reg     <= cfg_data[GROUP_SIZE_W-1:0];
                CFG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[CHANNEL_COUNT_W-1:0];
                CFG_INV_GROUP_SIZE: inv_group_size_reg <= cfg_data[INV_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_pos_reg     <= '0;
            row_pos_reg    <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            mean_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CH_W'(1);
                if (CC_W'(clr_addr_reg) == CH_LAST)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                ch_pos_reg  <= ch_pos_next;
                row_pos_reg <= row_pos_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_move && s1_last_row_reg;
            end
            if (out_ready)
            begin
                mean_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Sum memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sum_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= sum_mem[ch_eff];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (accept)
        begin
            s1_ch_reg        <= ch_eff;
            s1_x_reg         <= sample_value;
            s1_last_row_reg  <= last_row;
            s1_last_chan_reg <= last_chan;
        end
        if (s1_move && s1_last_row_reg && s2_ready)
        begin
            s2_total_reg <= total;
            s2_end_reg   <= s1_last_chan_reg;
        end
        if (s2_move)
        begin
            mean_value_reg <= mean_next;
            vector_end_reg <= s2_end_reg;
        end
    end

    assign mean_valid = mean_valid_reg;
    assign mean_value = mean_value_reg;
    assign vector_end = vector_end_reg;

    // The clearing pass owns the sum memory: no sample enters and no write-back occurs.
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (sample_stall && !s1_valid_reg))
        else $error("Sample pipeline active during the clearing pass.");

    // A mean waiting in the scale stage behind a stalled output is kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && mean_valid_reg && mean_stall) |=> (s2_valid_reg && $stable(s2_total_reg)))
        else $error("Scale stage lost a pending mean.");

    // An accumulate stage that does not move keeps its transaction and its channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_ch_reg)))
        else $error("Accumulate stage dropped a transaction without writing it back.");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the group mean vector unit.
`timescale 1ns / 1ps

module tb_top;
    import gmv_pkg::*;

    typedef logic signed [DEF_DATA_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t mean;
        logic    last;
    } mean_rec_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_BURSTY} stall_mode_t;

    localparam int      CLK_HALF      = 6;
    localparam int      CYCLE_LIMIT   = 500000;
    localparam int      SETTLE_CYCLES = 8;
    localparam int      RANDOM_ITEMS  = 700;
    localparam int      MAX_REPORTS   = 10;
    localparam longint MEAN_MAX      = (longint'(1) << (DEF_DATA_WIDTH - 1)) - 1;
    localparam longint MEAN_MIN      = -MEAN_MAX - 1;
    localparam longint SUM_MAX       = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint SUM_MIN       = -SUM_MAX - 1;
    localparam sample_t SAMPLE_MAX    = {1'b0, {(DEF_DATA_WIDTH - 1){1'b1}}};
    localparam sample_t SAMPLE_MIN    = {1'b1, {(DEF_DATA_WIDTH - 1){1'b0}}};
    localparam logic [6:0] STALL_PATTERN_BITS = 7'b1011000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       sample_valid;
    logic                       sample_stall;
    sample_t                    sample_value;
    logic                       mean_valid;
    logic                       mean_stall;
    sample_t                    mean_value;
    logic                       vector_end;

    // Predictor state, a copy of what the block holds.
    logic signed [ACC_W-1:0]    sum_mem [DEF_MAX_CHANNELS];
    logic [8:0]                 next_channel;
    logic [7:0]                 next_row;
    logic [GROUP_SIZE_W-1:0]    group_reg;
    logic [CHANNEL_COUNT_W-1:0] chan_reg;
    logic [INV_W-1:0]           inv_reg;

    mean_rec_t   pending_means[$];
    int          error_count   = 0;
    int          items_sent    = 0;
    int          means_checked = 0;
    int          config_phases = 0;
    int          cycle_count   = 0;
    int          hold_left     = 0;
    int          burst_left    = 0;
    bit          sender_gaps   = 1'b0;
    stall_mode_t stall_mode    = STALL_NONE;

    group_mean_vector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .mean_valid   (mean_valid),
        .mean_stall   (mean_stall),
        .mean_value   (mean_value),
        .vector_end   (vector_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL group_mean_vector_unit");
            $finish;
        end
    end

    function automatic void reset_model();
        foreach (sum_mem[i])
        begin
            sum_mem[i] = '0;
        end
        next_channel = '0;
        next_row     = '0;
        group_reg    = GROUP_SIZE_RST;
        chan_reg     = CHANNEL_COUNT_RST;
        inv_reg      = INV_GROUP_SIZE_RST;
    endfunction

    function automatic void predict_mean(input sample_t x);
        int        rows;
        int        chans;
        int        ch;
        bit        last_row;
        bit        last_chan;
        longint    total;
        longint    q;
        mean_rec_t rec;
        rows  = int'(group_reg);
        chans = int'(chan_reg);
        if (rows < 1) rows = 1;
        if (rows > DEF_MAX_GROUP) rows = DEF_MAX_GROUP;
        if (chans < 1) chans = 1;
        if (chans > DEF_MAX_CHANNELS) chans = DEF_MAX_CHANNELS;
        ch = int'(next_channel);
        if (ch >= DEF_MAX_CHANNELS) ch = DEF_MAX_CHANNELS - 1;
        last_chan = (ch >= chans - 1);
        last_row  = (int'(next_row) >= rows - 1);
        total     = longint'(sum_mem[ch]) + longint'(x);
        if (last_row)
        begin
            q = (total * longint'(inv_reg)) >>> FRAC_W;
            if (q > MEAN_MAX) q = MEAN_MAX;
            if (q < MEAN_MIN) q = MEAN_MIN;
            rec.mean = sample_t'(q);
            rec.last = last_chan;
            pending_means.push_back(rec);
            sum_mem[ch] = '0;
        end
        else
        begin
            if (total > SUM_MAX) total = SUM_MAX;
            if (total < SUM_MIN) total = SUM_MIN;
            sum_mem[ch] = ACC_W'(total);
        end
        if (last_chan)
        begin
            next_channel = '0;
            next_row     = last_row ? 8'd0 : next_row + 8'd1;
        end
        else
        begin
            next_channel = 9'(ch + 1);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_means
        mean_rec_t want;
        if (rst_n && mean_valid && !mean_stall)
        begin
            means_checked++;
            if (pending_means.size() == 0)
            begin
                note_mismatch($sformatf("unexpected mean %0d end %0b", mean_value, vector_end));
            end
            else
            begin
                want = pending_means.pop_front();
                if (mean_value !== want.mean || vector_end !== want.last)
                    note_mismatch($sformatf("expected mean %0d end %0b, got mean %0d end %0b",
                                            want.mean, want.last, mean_value, vector_end));
            end
        end
    end

    initial
    begin : mean_receiver
        int run_left;
        bit run_stalled;
        int pat_pos;
        run_left    = 0;
        run_stalled = 1'b0;
        pat_pos     = 0;
        mean_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                mean_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:
                        mean_stall <= 1'b0;
                    STALL_RANDOM:
                        mean_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PATTERN:
                    begin
                        mean_stall <= STALL_PATTERN_BITS[pat_pos];
                        pat_pos = (pat_pos + 1) % 7;
                    end
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_stalled = !run_stalled;
                            run_left = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 5);
                        end
                        run_left--;
                        mean_stall <= run_stalled;
                    end
                endcase
            end
        end
    end

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        sample_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_sample(input sample_t v);
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(1, 5));
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample_value <= v;
        do @(posedge clk); while (sample_stall);
        predict_mean(v);
        items_sent++;
    endtask

    // Waits until every expected mean has come out and the pipeline has gone quiet.
    task automatic settle();
        pause_sender(1);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_GROUP_SIZE:    group_reg = GROUP_SIZE_W'(value);
            CFG_CHANNEL_COUNT: chan_reg  = CHANNEL_COUNT_W'(value);
            default:           inv_reg   = INV_W'(value);
        endcase
    endtask

    task automatic configure(input int group, input int chans, input int inv);
        settle();
        write_reg(CFG_GROUP_SIZE, group);
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_INV_GROUP_SIZE, inv);
        config_phases++;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic test_reset_defaults();
        sample_t vals[7];
        vals = '{SAMPLE_MIN, SAMPLE_MAX, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555, 16'shAAAA};
        stall_mode  = STALL_RANDOM;
        sender_gaps = 1'b1;
        foreach (vals[i])
        begin
            send_sample(vals[i]);
        end
    endtask

    task automatic test_group_average();
        configure(4, 3, 16384);
        repeat (4)
        begin
            send_sample(SAMPLE_MIN);
            send_sample(SAMPLE_MAX);
            send_sample(sample_t'(0));
        end
    endtask

    task automatic test_register_extremes();
        sample_t vals[3];
        vals = '{16'sd20000, -16'sd20000, 16'sd5};
        configure(0, 0, 0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        configure(1, 1023, 131071);
        foreach (vals[i])
        begin
            send_sample(vals[i]);
        end
        settle();
        write_reg(CFG_CHANNEL_COUNT, 2);
        send_sample(-16'sd7);
        configure(511, 1, 256);
        repeat (3) send_sample(pick_sample());
        settle();
        write_reg(CFG_GROUP_SIZE, 2);
        write_reg(CFG_INV_GROUP_SIZE, 32768);
        send_sample(pick_sample());
    endtask

    // Drives one channel's sum past the accumulator range by carrying it across a group end.
    task automatic test_accumulator_saturation();
        stall_mode  = STALL_NONE;
        sender_gaps = 1'b0;
        configure(DEF_MAX_GROUP, 2, 256);
        repeat (2 * (DEF_MAX_GROUP - 1)) send_sample(SAMPLE_MAX);
        settle();
        write_reg(CFG_CHANNEL_COUNT, 1);
        send_sample(SAMPLE_MAX);
        settle();
        write_reg(CFG_CHANNEL_COUNT, 2);
        repeat (4) send_sample(SAMPLE_MAX);
        settle();
        write_reg(CFG_GROUP_SIZE, 1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
    endtask

    task automatic test_output_backpressure();
        configure(1, 5, 65536);
        stall_mode  = STALL_NONE;
        sender_gaps = 1'b0;
        hold_left   = 300;
        repeat (64) send_sample(pick_sample());
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int group;
        int chans;
        int rows;
        int inv;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    group = $urandom_range(200, 511);
                    chans = $urandom_range(1, 3);
                end
                1:
                begin
                    group = $urandom_range(0, 2);
                    chans = $urandom_range(300, 1023);
                end
                default:
                begin
                    group = $urandom_range(0, 6);
                    chans = $urandom_range(0, 8);
                end
            endcase
            rows = (group < 1) ? 1 : (group > DEF_MAX_GROUP) ? DEF_MAX_GROUP : group;
            case ($urandom_range(0, 7))
                0:       inv = $urandom_range(0, 131071);
                1:       inv = ($urandom_range(0, 1) == 0) ? 0 : 131071;
                default: inv = (65536 + rows / 2) / rows;
            endcase
            configure(group, chans, inv);
            stall_mode  = stall_mode_t'($urandom_range(0, 3));
            sender_gaps = ($urandom_range(0, 2) != 0);
            phase_len   = $urandom_range(20, 60);
            repeat (phase_len) send_sample(pick_sample());
            sent += phase_len;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_GROUP_SIZE;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample_value = '0;
        reset_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_group_average();
        test_register_extremes();
        test_accumulator_saturation();
        test_output_backpressure();
        test_random_traffic();
        settle();

        $display("Sent %0d samples through %0d register settings and checked %0d means.",
                 items_sent, config_phases, means_checked);
        $display("Covered clamped registers, saturation, mid-group changes and stalls; %0d errors.",
                 error_count);
        if (error_count == 0)
            $display("PASS group_mean_vector_unit");
        else
            $display("FAIL group_mean_vector_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
design/gmv_pkg.sv
design/group_mean_vector_unit.sv
bench/tb_top.sv
